### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

### rtl/sksb_pkg.sv
// Types and constants for the stable key sort with run batching.
`timescale 1ns / 1ps
`default_nettype none

package sksb_pkg;

    localparam int MAX_QUADS_DEF = 64;
    localparam int KEY_WIDTH_DEF = 16;
    localparam int INDEX_W       = 6;

    typedef struct packed {
        logic [15:0] paint_key;
        logic        is_opaque;
        logic        last_quad;
    } quad_t;

    typedef struct packed {
        logic [INDEX_W-1:0] quad_index;
        logic               batch_opaque;
        logic               new_batch;
        logic               overflow;
        logic               last_of_run;
    } draw_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/sksb_cell.sv
// One cell of the insertion chain: holds one sorted entry.
`timescale 1ns / 1ps
`default_nettype none

module sksb_cell #(
    parameter int KEY_WIDTH = sksb_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sksb_pkg::cell_ctrl_t         ctrl,
    input  wire logic [KEY_WIDTH-1:0]         new_key,
    input  wire logic [sksb_pkg::INDEX_W-1:0] new_index,
    input  wire logic                         new_opaque,
    input  wire logic                         prev_valid,
    input  wire logic                         prev_greater,
    input  wire logic [KEY_WIDTH-1:0]         prev_key,
    input  wire logic [sksb_pkg::INDEX_W-1:0] prev_index,
    input  wire logic                         prev_opaque,
    input  wire logic                         succ_valid,
    input  wire logic [KEY_WIDTH-1:0]         succ_key,
    input  wire logic [sksb_pkg::INDEX_W-1:0] succ_index,
    input  wire logic                         succ_opaque,
    output logic                              valid,
    output logic                              greater,
    output logic [KEY_WIDTH-1:0]              key,
    output logic [sksb_pkg::INDEX_W-1:0]      index,
    output logic                              opaque
);

    logic                         valid_reg, valid_next;
    logic [KEY_WIDTH-1:0]         key_reg, key_next;
    logic [sksb_pkg::INDEX_W-1:0] index_reg, index_next;
    logic                         opaque_reg, opaque_next;

    // Strictly greater keys move up, so equal keys keep arrival order.
    assign greater = valid_reg && (key_reg > new_key);

    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        index_next  = index_reg;
        opaque_next = opaque_reg;
        if (ctrl.drain)
        begin
            valid_next  = succ_valid;
            key_next    = succ_key;
            index_next  = succ_index;
            opaque_next = succ_opaque;
        end
        else if (ctrl.insert)
        begin
            if (prev_greater)
            begin
                valid_next  = 1'b1;
                key_next    = prev_key;
                index_next  = prev_index;
                opaque_next = prev_opaque;
            end
            else if (greater || (!valid_reg && prev_valid))
            begin
                valid_next  = 1'b1;
                key_next    = new_key;
                index_next  = new_index;
                opaque_next = new_opaque;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        index_reg  <= index_next;
        opaque_reg <= opaque_next;
    end

    assign valid  = valid_reg;
    assign key    = key_reg;
    assign index  = index_reg;
    assign opaque = opaque_reg;

endmodule

`default_nettype wire

### rtl/stable_key_sort_with_run_batching.sv
// Top level: stable insertion sort of quads by key, drained in batches.
//
//   channel   dir  valid        stall        payload
//   quad      in   quad_valid   quad_stall   quad (sksb_pkg::quad_t)
//   draw      out  draw_valid   draw_stall   draw (sksb_pkg::draw_t)
//
// Loading takes one quad per cycle; every cell of the chain compares and
// shifts in the same cycle. After the quad marked last, the chain drains one
// entry per cycle through cell 0 while the output does not stall; quad_stall
// is high during the drain.
// Reset empties the chain and clears the count and overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module stable_key_sort_with_run_batching #(
    parameter int MAX_QUADS = sksb_pkg::MAX_QUADS_DEF,
    parameter int KEY_WIDTH = sksb_pkg::KEY_WIDTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            quad_valid,
    output logic                 quad_stall,
    input  wire sksb_pkg::quad_t quad,
    output logic                 draw_valid,
    input  wire logic            draw_stall,
    output sksb_pkg::draw_t      draw
);

    localparam int CNT_W = $clog2(MAX_QUADS + 1);
    localparam int IW    = sksb_pkg::INDEX_W;

    sksb_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     quad_count_reg, quad_count_next;
    logic                 overflow_seen_reg, overflow_seen_next;
    logic                 first_reg, first_next;
    logic                 prev_opaque_reg, prev_opaque_next;
    logic                 draw_valid_reg, draw_valid_next;
    sksb_pkg::draw_t      draw_reg, draw_next;
    sksb_pkg::cell_ctrl_t ctrl;

    logic                 valid_c   [MAX_QUADS];
    logic                 greater_c [MAX_QUADS];
    logic [KEY_WIDTH-1:0] key_c     [MAX_QUADS];
    logic [IW-1:0]        index_c   [MAX_QUADS];
    logic                 opaque_c  [MAX_QUADS];

    logic                 accept;
    logic                 full;
    logic                 load_out;
    logic                 more_left;
    logic [KEY_WIDTH-1:0] new_key;
    logic [IW-1:0]        new_index;

    assign quad_stall = (state_reg != sksb_pkg::ST_LOAD);
    assign accept     = quad_valid && !quad_stall;
    assign full       = valid_c[MAX_QUADS-1];
    assign new_key    = KEY_WIDTH'(quad.paint_key);
    assign new_index  = IW'(quad_count_reg);
    assign load_out   = (state_reg == sksb_pkg::ST_DRAIN) && (!draw_valid_reg || !draw_stall);

    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = load_out;

    generate
        if (MAX_QUADS > 1)
        begin : g_more
            assign more_left = valid_c[1];
        end
        else
        begin : g_single
            assign more_left = 1'b0;
        end
    endgenerate

    for (genvar i = 0; i < MAX_QUADS; i++)
    begin : g_cell
        logic                 p_valid, p_greater, p_opaque;
        logic [KEY_WIDTH-1:0] p_key;
        logic [IW-1:0]        p_index;
        logic                 s_valid, s_opaque;
        logic [KEY_WIDTH-1:0] s_key;
        logic [IW-1:0]        s_index;

        if (i == 0)
        begin : g_head
            assign p_valid   = 1'b1;
            assign p_greater = 1'b0;
            assign p_key     = '0;
            assign p_index   = '0;
            assign p_opaque  = 1'b0;
        end
        else
        begin : g_link
            assign p_valid   = valid_c[i-1];
            assign p_greater = greater_c[i-1];
            assign p_key     = key_c[i-1];
            assign p_index   = index_c[i-1];
            assign p_opaque  = opaque_c[i-1];
        end

        if (i == MAX_QUADS - 1)
        begin : g_tail
            assign s_valid  = 1'b0;
            assign s_key    = '0;
            assign s_index  = '0;
            assign s_opaque = 1'b0;
        end
        else
        begin : g_next
            assign s_valid  = valid_c[i+1];
            assign s_key    = key_c[i+1];
            assign s_index  = index_c[i+1];
            assign s_opaque = opaque_c[i+1];
        end

        sksb_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .new_key      (new_key),
            .new_index    (new_index),
            .new_opaque   (quad.is_opaque),
            .prev_valid   (p_valid),
            .prev_greater (p_greater),
            .prev_key     (p_key),
            .prev_index   (p_index),
            .prev_opaque  (p_opaque),
            .succ_valid   (s_valid),
            .succ_key     (s_key),
            .succ_index   (s_index),
            .succ_opaque  (s_opaque),
            .valid        (valid_c[i]),
            .greater      (greater_c[i]),
            .key          (key_c[i]),
            .index        (index_c[i]),
            .opaque       (opaque_c[i])
        );
    end

    always_comb
    begin
        state_next         = state_reg;
        quad_count_next    = quad_count_reg;
        overflow_seen_next = overflow_seen_reg;
        first_next         = first_reg;
        prev_opaque_next   = prev_opaque_reg;
        draw_valid_next    = draw_valid_reg && draw_stall;
        draw_next          = draw_reg;
        case (state_reg)
            sksb_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        overflow_seen_next = 1'b1;
                    end
                    else
                    begin
                        quad_count_next = quad_count_reg + CNT_W'(1);
                    end
                    if (quad.last_quad)
                    begin
                        state_next = sksb_pkg::ST_DRAIN;
                    end
                end
            end
            sksb_pkg::ST_DRAIN:
            begin
                if (load_out)
                begin
                    draw_valid_next         = 1'b1;
                    draw_next.quad_index    = index_c[0];
                    draw_next.batch_opaque  = opaque_c[0];
                    draw_next.new_batch     = first_reg || (opaque_c[0] != prev_opaque_reg);
                    draw_next.overflow      = overflow_seen_reg;
                    draw_next.last_of_run   = !more_left;
                    first_next              = 1'b0;
                    prev_opaque_next        = opaque_c[0];
                    // Final entry out: start a fresh snapshot.
                    if (!more_left)
                    begin
                        state_next         = sksb_pkg::ST_LOAD;
                        quad_count_next    = '0;
                        overflow_seen_next = 1'b0;
                        first_next         = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sksb_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= sksb_pkg::ST_LOAD;
            quad_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            first_reg         <= 1'b1;
            draw_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            quad_count_reg    <= quad_count_next;
            overflow_seen_reg <= overflow_seen_next;
            first_reg         <= first_next;
            draw_valid_reg    <= draw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_opaque_reg <= prev_opaque_next;
        draw_reg        <= draw_next;
    end

    assign draw_valid = draw_valid_reg;
    assign draw       = draw_reg;

endmodule

`default_nettype wire

### rtl/sksb_checker.sv
// Port-level checker for the stable key sort, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sksb_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            quad_valid,
    input wire logic            quad_stall,
    input wire sksb_pkg::quad_t quad,
    input wire logic            draw_valid,
    input wire logic            draw_stall,
    input wire sksb_pkg::draw_t draw
);

    // A stalled result holds until its transfer.
    `ASSERT_NEXT(a_draw_hold, clk, rst_n, draw_valid && draw_stall, draw_valid && $stable(draw))

    // The transfer of a last quad starts the drain.
    `ASSERT_NEXT(a_last_stalls, clk, rst_n, quad_valid && !quad_stall && quad.last_quad, quad_stall)

    // A pending result that is not the final one means the drain still runs.
    `ASSERT_SAME(a_mid_run_stall, clk, rst_n, draw_valid && !draw.last_of_run, quad_stall)

endmodule

bind stable_key_sort_with_run_batching sksb_checker u_sksb_checker (.*);

`default_nettype wire

### tb/tb_stable_key_sort_with_run_batching.sv
// Self-checking testbench for the stable key sort with run batching block.
`timescale 1ns / 1ps

module tb_stable_key_sort_with_run_batching;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 2 * sksb_pkg::MAX_QUADS_DEF + 8;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        logic [15:0]                  key;
        logic [sksb_pkg::INDEX_W-1:0] idx;
        logic                         opq;
    } sorted_entry_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            quad_valid = 1'b0;
    logic            quad_stall;
    sksb_pkg::quad_t quad = '0;
    logic            draw_valid;
    logic            draw_stall = 1'b0;
    sksb_pkg::draw_t draw;

    // predicted state for the snapshot being loaded
    sorted_entry_t   sorted_quads[$];
    bit              quads_dropped = 1'b0;
    sksb_pkg::draw_t draws_due[$];
    int              mismatches = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    stable_key_sort_with_run_batching DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .quad_valid (quad_valid),
        .quad_stall (quad_stall),
        .quad       (quad),
        .draw_valid (draw_valid),
        .draw_stall (draw_stall),
        .draw       (draw)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Insert one quad into the sorted list; on the last quad, queue the draw order.
    function automatic void predict_quad(sksb_pkg::quad_t q);
        sorted_entry_t   e;
        sksb_pkg::draw_t d;
        int              pos;
        logic            prev_opq;
        if (sorted_quads.size() < sksb_pkg::MAX_QUADS_DEF)
        begin
            e.key = q.paint_key;
            e.idx = sksb_pkg::INDEX_W'(sorted_quads.size());
            e.opq = q.is_opaque;
            pos = sorted_quads.size();
            // go after every entry with a key less than or equal
            while (pos > 0 && sorted_quads[pos-1].key > e.key)
                pos--;
            sorted_quads.insert(pos, e);
        end
        else
            quads_dropped = 1'b1;
        if (q.last_quad)
        begin
            prev_opq = 1'b0;
            foreach (sorted_quads[k])
            begin
                d.quad_index   = sorted_quads[k].idx;
                d.batch_opaque = sorted_quads[k].opq;
                d.new_batch    = (k == 0) || (sorted_quads[k].opq != prev_opq);
                d.overflow     = quads_dropped;
                d.last_of_run  = (k == sorted_quads.size() - 1);
                prev_opq = sorted_quads[k].opq;
                draws_due.insert(draws_due.size(), d);
            end
            sorted_quads.delete();
            quads_dropped = 1'b0;
        end
    endfunction

    function automatic void flag_field(string name, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function automatic void check_draw(sksb_pkg::draw_t got);
        sksb_pkg::draw_t want;
        if (draws_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected draw transfer: expected none, actual %h", $time, got);
            return;
        end
        want = draws_due.pop_front();
        if (got.quad_index !== want.quad_index)
            flag_field("quad_index", want.quad_index, got.quad_index);
        if (got.batch_opaque !== want.batch_opaque)
            flag_field("batch_opaque", want.batch_opaque, got.batch_opaque);
        if (got.new_batch !== want.new_batch)
            flag_field("new_batch", want.new_batch, got.new_batch);
        if (got.overflow !== want.overflow)
            flag_field("overflow", want.overflow, got.overflow);
        if (got.last_of_run !== want.last_of_run)
            flag_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    // Values read here are the ones present at the edge.
    always @(posedge clk)
    begin
        if (rst_n && quad_valid && !quad_stall)
            predict_quad(quad);
        if (rst_n && draw_valid && !draw_stall)
            check_draw(draw);
    end

    // Output stall: a requested hold-off first, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen  <= hold_token;
            hold_left  <= hold_len;
            draw_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left  <= hold_left - 1;
            draw_stall <= 1'b1;
        end
        else
            draw_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((quad_valid && !quad_stall) || (draw_valid && !draw_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_stable_key_sort_with_run_batching: FAIL");
        $finish;
    end

    // Offer one quad and hold it until the transfer; valid is not dropped afterward.
    task automatic send_quad(input logic [15:0] key, input logic opq, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            quad_valid <= 1'b0;
            @(posedge clk);
        end
        quad_valid      <= 1'b1;
        quad.paint_key  <= key;
        quad.is_opaque  <= opq;
        quad.last_quad  <= last;
        do
            @(posedge clk);
        while (quad_stall);
    endtask

    // Drop valid, let the monitor see the final transfer, then wait for all draws.
    task automatic wait_draws_done();
        quad_valid <= 1'b0;
        @(posedge clk);
        while (draws_due.size() != 0)
            @(posedge clk);
    endtask

    // One snapshot of n quads; key_span 0 means the full key range.
    task automatic send_snapshot(input int n, input int key_span, input int flip_pct);
        logic [15:0] key;
        logic        opq;
        opq = 1'($urandom_range(1));
        for (int i = 0; i < n; i++)
        begin
            key = (key_span == 0) ? 16'($urandom_range(16'hFFFF))
                                  : 16'($urandom_range(key_span));
            if ($urandom_range(99) < flip_pct)
                opq = ~opq;
            send_quad(key, opq, i == n - 1);
        end
    endtask

    task automatic test_directed();
        // one-quad snapshot
        send_quad(16'h1234, 1'b1, 1'b1);
        // key extremes, equal keys keep arrival order
        send_quad(16'hFFFF, 1'b1, 1'b0);
        send_quad(16'h0000, 1'b0, 1'b0);
        send_quad(16'hFFFF, 1'b0, 1'b0);
        send_quad(16'h0000, 1'b1, 1'b1);
        // reverse order, opacity alternating
        send_quad(16'd50, 1'b0, 1'b0);
        send_quad(16'd40, 1'b1, 1'b0);
        send_quad(16'd30, 1'b0, 1'b0);
        send_quad(16'd20, 1'b1, 1'b0);
        send_quad(16'd10, 1'b0, 1'b1);
        // all keys equal, opacity runs
        send_quad(16'd7, 1'b0, 1'b0);
        send_quad(16'd7, 1'b0, 1'b0);
        send_quad(16'd7, 1'b1, 1'b0);
        send_quad(16'd7, 1'b1, 1'b0);
        send_quad(16'd7, 1'b0, 1'b1);
        // toggling key bits, single batch
        send_quad(16'h5555, 1'b1, 1'b0);
        send_quad(16'hAAAA, 1'b1, 1'b0);
        send_quad(16'h8001, 1'b1, 1'b1);
    endtask

    task automatic test_full_store();
        // exactly full, no drop
        send_snapshot(sksb_pkg::MAX_QUADS_DEF, 0, 20);
        // two quads past capacity, last two dropped yet output still comes
        send_snapshot(sksb_pkg::MAX_QUADS_DEF + 2, 15, 30);
    endtask

    task automatic test_random_snapshots(input int budget, input int sidle, input int rstall);
        int sent;
        int n;
        int pick;
        int span;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                n = $urandom_range(12, 1);
            else if (pick < 95)
                n = $urandom_range(40, 13);
            else
                n = $urandom_range(sksb_pkg::MAX_QUADS_DEF + 4, sksb_pkg::MAX_QUADS_DEF - 4);
            case ($urandom_range(2))
                0: span = 0;
                1: span = 3;
                default: span = 255;
            endcase
            send_snapshot(n, span, $urandom_range(100));
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = 150;
        hold_token++;
        for (int s = 0; s < 4; s++)
            send_snapshot(8, 0, 50);
        // pause the source until every draw has been seen
        wait_draws_done();
        send_snapshot(6, 3, 50);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_random_snapshots(70, 0, 0);
        test_random_snapshots(70, 66, 0);
        test_random_snapshots(70, 0, 66);
        test_random_snapshots(70, 16, 16);
        test_backpressure();

        wait_draws_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && draws_due.size() == 0)
            $display("tb_stable_key_sort_with_run_batching: PASS");
        else
            $display("tb_stable_key_sort_with_run_batching: FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sksb_pkg.sv
rtl/sksb_cell.sv
rtl/stable_key_sort_with_run_batching.sv
rtl/sksb_checker.sv
tb/tb_stable_key_sort_with_run_batching.sv
